@@ hw/rtl/spgp_pkg.sv @@
// Shared types and constants of the seven-point grid prolongation block.
// No dependencies; used by the top level, the front end, the back end and the testbench.
package spgp_pkg;

  localparam int FINE_IDX_W  = 12;
  localparam int VALUE_W     = 32;
  localparam int CFG_W       = 11;
  localparam int OUT_TDATA_W = 2 * FINE_IDX_W + VALUE_W;

  typedef enum logic [0:0] {
    REG_INTERVALS_X = 1'b0,
    REG_INTERVALS_Y = 1'b1
  } cfg_reg_e;

  // output beat kinds of one coarse sample, in emission order
  typedef enum logic [1:0] {
    PH_DIAG = 2'd0,
    PH_UP   = 2'd1,
    PH_LEFT = 2'd2,
    PH_SELF = 2'd3
  } phase_e;

  // control part of one queued job: even fine indices and neighbor flags
  typedef struct packed {
    logic [FINE_IDX_W-1:0] row2;
    logic [FINE_IDX_W-1:0] col2;
    logic                  has_up;
    logic                  has_left;
    logic                  grid_end;
  } job_ctrl_t;

endpackage

@@ hw/rtl/seven_point_grid_prolongation.sv @@
// Each coarse sample gives one to four fine points, one per cycle on the output channel
// while that channel is ready; samples are taken back to back.
// First fine point of a sample passes stage 1, the queue, the job reg and the output reg.
// The previous-row store is a RAM without clearing pass; reset clears counters, neighbor registers
// and pipeline valids, and interval registers reset to 1. A register write restarts the grid.
module seven_point_grid_prolongation #(
  parameter int MAX_INTERVALS = 1024,
  parameter int SAMPLE_WIDTH  = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // coarse_value
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [spgp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // fine_row, fine_col, fine_value
  output logic                                 m_axis_tlast,  // last_of_grid
  output logic [0:0]                           m_axis_tuser,  // last_of_input
  input  logic                                 cfg_we_i,
  input  spgp_pkg::cfg_reg_e                   cfg_index_i,
  input  logic [spgp_pkg::CFG_W-1:0]           cfg_wdata_i
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CW    = $clog2(MAX_INTERVALS + 1);
  localparam int KW    = (CW > spgp_pkg::CFG_W) ? CW : spgp_pkg::CFG_W;
  localparam int JOB_W = $bits(spgp_pkg::job_ctrl_t) + 4 * SW;
  localparam int FW    = spgp_pkg::FINE_IDX_W;
  localparam int VW    = spgp_pkg::VALUE_W;

  logic [CW-1:0] nx_q, nx_d, ny_q, ny_d, clamped;
  logic [KW-1:0] wdata_ext;

  logic                push, full, pop, job_valid;
  spgp_pkg::job_ctrl_t f_ctrl, b_ctrl;
  logic [SW-1:0]       f_v, f_above, f_prev, f_ul;
  logic [SW-1:0]       b_v, b_above, b_prev, b_ul;
  logic [JOB_W-1:0]    job_in, job_out;

  logic [FW-1:0] m_row, m_col;
  logic [VW-1:0] m_value;
  logic          m_last_input, m_last_grid;

  // zero counts as one interval, large values saturate at MAX_INTERVALS
  assign wdata_ext = KW'(cfg_wdata_i);
  always_comb begin
    if (wdata_ext == '0) begin
      clamped = CW'(1);
    end else if (wdata_ext > KW'(MAX_INTERVALS)) begin
      clamped = CW'(MAX_INTERVALS);
    end else begin
      clamped = CW'(wdata_ext);
    end
  end

  always_comb begin
    nx_d = nx_q;
    ny_d = ny_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        spgp_pkg::REG_INTERVALS_X: nx_d = clamped;
        spgp_pkg::REG_INTERVALS_Y: ny_d = clamped;
        default: begin
          nx_d = nx_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q <= CW'(1);
      ny_q <= CW'(1);
    end else begin
      nx_q <= nx_d;
      ny_q <= ny_d;
    end
  end

  spgp_front #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .nx_i      (nx_q),
    .ny_i      (ny_q),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata[SW-1:0]),
    .full_i    (full),
    .push_o    (push),
    .ctrl_o    (f_ctrl),
    .v_o       (f_v),
    .above_o   (f_above),
    .prev_o    (f_prev),
    .ul_o      (f_ul)
  );

  assign job_in = {f_ctrl, f_v, f_above, f_prev, f_ul};

  spgp_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (job_out),
    .valid_o (job_valid)
  );

  assign {b_ctrl, b_v, b_above, b_prev, b_ul} = job_out;

  spgp_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_pop_o      (pop),
    .ctrl_i         (b_ctrl),
    .v_i            (b_v),
    .above_i        (b_above),
    .prev_i         (b_prev),
    .ul_i           (b_ul),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .m_row_o        (m_row),
    .m_col_o        (m_col),
    .m_value_o      (m_value),
    .m_last_input_o (m_last_input),
    .m_last_grid_o  (m_last_grid)
  );

  assign m_axis_tdata = {m_value, m_col, m_row};
  assign m_axis_tlast = m_last_grid;
  assign m_axis_tuser = m_last_input;

endmodule

@@ hw/rtl/spgp_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module spgp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/spgp_fifo.sv @@
// Short flop-based queue between the front and back of the block.
// No package dependencies.
module spgp_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             valid_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  always_comb begin
    wptr_d = push_i ? ptr_inc(wptr_q) : wptr_q;
    rptr_d = pop_i ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wptr_q] <= wdata_i;
    end
  end

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = data_q[rptr_q];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("queue push while full");
`endif

endmodule

@@ hw/rtl/spgp_front.sv @@
// Front end: accepts coarse samples, tracks the grid position, reads and
// writes the previous-row store and builds jobs. Depends on spgp_pkg, spgp_ram.
module spgp_front #(
  parameter int MAX_INTERVALS = 1024,
  parameter int SAMPLE_WIDTH  = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 restart_i,
  input  logic [$clog2(MAX_INTERVALS+1)-1:0]   nx_i,
  input  logic [$clog2(MAX_INTERVALS+1)-1:0]   ny_i,
  input  logic                                 s_valid_i,
  output logic                                 s_ready_o,
  input  logic [SAMPLE_WIDTH-1:0]              s_data_i,
  input  logic                                 full_i,
  output logic                                 push_o,
  output spgp_pkg::job_ctrl_t                  ctrl_o,
  output logic [SAMPLE_WIDTH-1:0]              v_o,
  output logic [SAMPLE_WIDTH-1:0]              above_o,
  output logic [SAMPLE_WIDTH-1:0]              prev_o,
  output logic [SAMPLE_WIDTH-1:0]              ul_o
);

  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int FW = spgp_pkg::FINE_IDX_W;
  localparam int SW = SAMPLE_WIDTH;

  logic          accept, push;
  logic          col_end, row_end;
  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [CW:0]   col2_full, row2_full;

  logic                s1_valid_q, s1_valid_d;
  logic [SW-1:0]       s1_v_q;
  logic [CW-1:0]       s1_col_q;
  logic                s1_col_end_q;
  spgp_pkg::job_ctrl_t s1_ctrl_q;

  logic [SW-1:0] prev_q, prev_d, ul_q, ul_d, above;

  assign push      = s1_valid_q && !full_i;
  assign s_ready_o = !s1_valid_q || !full_i;
  assign accept    = s_valid_i && s_ready_o;
  assign col_end   = (col_q >= nx_i);
  assign row_end   = (row_q >= ny_i);
  assign col2_full = {col_q, 1'b0};
  assign row2_full = {row_q, 1'b0};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + CW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // left and up-left neighbors follow the job that leaves stage 1
  always_comb begin
    prev_d = prev_q;
    ul_d   = ul_q;
    if (restart_i) begin
      prev_d = '0;
      ul_d   = '0;
    end else if (push) begin
      prev_d = s1_col_end_q ? '0 : s1_v_q;
      ul_d   = s1_col_end_q ? '0 : above;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (push) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      prev_q     <= '0;
      ul_q       <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      prev_q     <= prev_d;
      ul_q       <= ul_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_v_q             <= s_data_i;
      s1_col_q           <= col_q;
      s1_col_end_q       <= col_end;
      s1_ctrl_q.row2     <= FW'(row2_full);
      s1_ctrl_q.col2     <= FW'(col2_full);
      s1_ctrl_q.has_up   <= (row_q != '0);
      s1_ctrl_q.has_left <= (col_q != '0);
      s1_ctrl_q.grid_end <= col_end && row_end;
    end
  end

  // entry is read when the sample is taken and rewritten as the job leaves
  spgp_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_INTERVALS + 1)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (s1_col_q),
    .wdata_i (s1_v_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (above)
  );

  assign push_o  = push;
  assign ctrl_o  = s1_ctrl_q;
  assign v_o     = s1_v_q;
  assign above_o = above;
  assign prev_o  = prev_q;
  assign ul_o    = ul_q;

endmodule

@@ hw/rtl/spgp_back.sv @@
// Back end: expands each job into up to four fine points, computes the
// floor means and drives the output register. Depends on spgp_pkg.
module spgp_back #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                job_valid_i,
  output logic                                job_pop_o,
  input  spgp_pkg::job_ctrl_t                 ctrl_i,
  input  logic [SAMPLE_WIDTH-1:0]             v_i,
  input  logic [SAMPLE_WIDTH-1:0]             above_i,
  input  logic [SAMPLE_WIDTH-1:0]             prev_i,
  input  logic [SAMPLE_WIDTH-1:0]             ul_i,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic [spgp_pkg::FINE_IDX_W-1:0]     m_row_o,
  output logic [spgp_pkg::FINE_IDX_W-1:0]     m_col_o,
  output logic [spgp_pkg::VALUE_W-1:0]        m_value_o,
  output logic                                m_last_input_o,
  output logic                                m_last_grid_o
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int FW    = spgp_pkg::FINE_IDX_W;
  localparam int VW    = spgp_pkg::VALUE_W;
  localparam int EXT_W = (SW > VW) ? SW : VW;

  function automatic logic [SW-1:0] mean2(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {a[SW-1], a} + {b[SW-1], b};
    return s[SW:1];
  endfunction

  logic                e_valid_q, e_valid_d;
  logic [3:0]          pend_q, pend_d, pend_left;
  spgp_pkg::job_ctrl_t e_ctrl_q;
  logic [SW-1:0]       e_v_q, e_above_q, e_prev_q, e_ul_q;

  spgp_pkg::phase_e       ph;
  logic                   out_free, emit, last_beat, load;
  logic [SW-1:0]          operand;
  logic signed [SW-1:0]   beat_val;
  logic [EXT_W-1:0]       val_ext;
  logic [FW-1:0]          beat_row, beat_col;

  logic          m_valid_q, m_valid_d;
  logic [FW-1:0] m_row_q, m_col_q;
  logic [VW-1:0] m_value_q;
  logic          m_last_input_q, m_last_grid_q;

  always_comb begin
    if (pend_q[spgp_pkg::PH_DIAG]) begin
      ph = spgp_pkg::PH_DIAG;
    end else if (pend_q[spgp_pkg::PH_UP]) begin
      ph = spgp_pkg::PH_UP;
    end else if (pend_q[spgp_pkg::PH_LEFT]) begin
      ph = spgp_pkg::PH_LEFT;
    end else begin
      ph = spgp_pkg::PH_SELF;
    end
  end

  assign pend_left = pend_q & ~(4'b0001 << ph);
  assign last_beat = (pend_left == '0);
  assign out_free  = !m_valid_q || m_ready_i;
  assign emit      = e_valid_q && out_free;
  assign load      = job_valid_i && (!e_valid_q || (emit && last_beat));

  always_comb begin
    beat_row = e_ctrl_q.row2;
    beat_col = e_ctrl_q.col2;
    operand  = e_v_q;
    case (ph)
      spgp_pkg::PH_DIAG: begin
        beat_row = e_ctrl_q.row2 - FW'(1);
        beat_col = e_ctrl_q.col2 - FW'(1);
        operand  = e_ul_q;
      end
      spgp_pkg::PH_UP: begin
        beat_row = e_ctrl_q.row2 - FW'(1);
        operand  = e_above_q;
      end
      spgp_pkg::PH_LEFT: begin
        beat_col = e_ctrl_q.col2 - FW'(1);
        operand  = e_prev_q;
      end
      default: begin
        operand = e_v_q;
      end
    endcase
  end

  // mean of a value with itself is the value, so the copy point shares the adder
  assign beat_val = mean2(operand, e_v_q);
  assign val_ext  = EXT_W'(beat_val);

  always_comb begin
    e_valid_d = e_valid_q;
    pend_d    = pend_q;
    if (load) begin
      e_valid_d = 1'b1;
      pend_d    = {1'b1, ctrl_i.has_left, ctrl_i.has_up, ctrl_i.has_up && ctrl_i.has_left};
    end else if (emit) begin
      pend_d = pend_left;
      if (last_beat) begin
        e_valid_d = 1'b0;
      end
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (emit) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      pend_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      e_valid_q <= e_valid_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      e_ctrl_q  <= ctrl_i;
      e_v_q     <= v_i;
      e_above_q <= above_i;
      e_prev_q  <= prev_i;
      e_ul_q    <= ul_i;
    end
    if (emit) begin
      m_row_q        <= beat_row;
      m_col_q        <= beat_col;
      m_value_q      <= val_ext[VW-1:0];
      m_last_input_q <= last_beat;
      m_last_grid_q  <= last_beat && e_ctrl_q.grid_end;
    end
  end

  assign job_pop_o      = load;
  assign m_valid_o      = m_valid_q;
  assign m_row_o        = m_row_q;
  assign m_col_o        = m_col_q;
  assign m_value_o      = m_value_q;
  assign m_last_input_o = m_last_input_q;
  assign m_last_grid_o  = m_last_grid_q;

`ifndef SYNTHESIS
  a_job_has_beats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_valid_q |-> (pend_q != '0))
    else $error("active job without pending points");
  a_diag_needs_sides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q[spgp_pkg::PH_DIAG] |-> (pend_q[spgp_pkg::PH_UP] && pend_q[spgp_pkg::PH_LEFT]))
    else $error("diagonal point without up and left points");
  a_grid_end_closes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_last_grid_q) |-> m_last_input_q)
    else $error("end of grid not on last point of a sample");
  a_self_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_beat) |-> (ph == spgp_pkg::PH_SELF))
    else $error("sample closed before its copy point");
`endif

endmodule

@@ test/tb_seven_point_grid_prolongation.sv @@
// Self-checking testbench for seven_point_grid_prolongation (coarse to fine grid upsampling).
// Needs spgp_pkg and the block's RTL; a built-in prolongation model predicts every fine point.
module tb_seven_point_grid_prolongation;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FINE_IDX_W  = spgp_pkg::FINE_IDX_W;
  localparam int VALUE_W     = spgp_pkg::VALUE_W;
  localparam int OUT_TDATA_W = spgp_pkg::OUT_TDATA_W;
  localparam int CFG_W       = spgp_pkg::CFG_W;

  localparam int MAX_IV      = 1024;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES  = 7;

  typedef struct {
    logic [FINE_IDX_W-1:0] row;
    logic [FINE_IDX_W-1:0] col;
    logic [VALUE_W-1:0]    value;
    logic                  last_in;
    logic                  last_grid;
  } fine_point_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [31:0]            s_axis_tdata  = '0;  // coarse_value
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // fine_row, fine_col, fine_value
  logic                   m_axis_tlast;  // last_of_grid
  logic [0:0]             m_axis_tuser;  // last_of_input
  logic                   cfg_we_i    = 1'b0;
  spgp_pkg::cfg_reg_e     cfg_index_i = spgp_pkg::REG_INTERVALS_X;
  logic [CFG_W-1:0]       cfg_wdata_i = '0;

  seven_point_grid_prolongation dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // model state
  logic [VALUE_W-1:0] row_above_mem [0:MAX_IV];
  logic [VALUE_W-1:0] left_val;
  logic [VALUE_W-1:0] diag_val;
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic [CFG_W-1:0]   intervals_x_reg = 11'd1;
  logic [CFG_W-1:0]   intervals_y_reg = 11'd1;

  logic [31:0] coarse_queue [$];
  fine_point_t expected_fine_points [$];

  int mismatches    = 0;
  int samples_sent  = 0;
  int points_seen   = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int cycle_count   = 0;

  // settings after the directed part: raw register values and sample counts
  logic [CFG_W-1:0] phase_x [NUM_PHASES] =
    '{11'd0, 11'd2047, 11'd0, 11'd3, 11'd1024, 11'd2, 11'd5};
  logic [CFG_W-1:0] phase_y [NUM_PHASES] =
    '{11'd0, 11'd0, 11'd2047, 11'd2, 11'd1024, 11'd1, 11'd3};
  int phase_items [NUM_PHASES] = '{8, 24, 12, 12, 6, 6, 24};

  // five full 2x2 grids at the reset setting, full-scale values first
  logic [31:0] directed_samples [20] = '{
    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
    32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFE,
    32'h0001_0000, 32'hFFFF_8000, 32'h0000_0003, 32'h5555_AAAA
  };

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_iv(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_IV) return MAX_IV;
    return v;
  endfunction

  // floor((a+b)/2) on the 33-bit sum
  function automatic logic [VALUE_W-1:0] mean_of(logic [VALUE_W-1:0] a,
                                                 logic [VALUE_W-1:0] b);
    logic signed [VALUE_W:0] s;
    s = $signed({a[VALUE_W-1], a}) + $signed({b[VALUE_W-1], b});
    return s[VALUE_W:1];
  endfunction

  function automatic fine_point_t make_point(int unsigned r, int unsigned c,
                                             logic [VALUE_W-1:0] v);
    fine_point_t p;
    p.row       = r[FINE_IDX_W-1:0];
    p.col       = c[FINE_IDX_W-1:0];
    p.value     = v;
    p.last_in   = 1'b0;
    p.last_grid = 1'b0;
    return p;
  endfunction

  function automatic logic [31:0] random_sample();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom_range(511) - 256;
      default: return $urandom;
    endcase
  endfunction

  task automatic prolongate_sample(input logic [VALUE_W-1:0] v);
    int unsigned nx, ny, r, c;
    logic [VALUE_W-1:0] above;
    fine_point_t batch [$];
    nx = clamp_iv(intervals_x_reg);
    ny = clamp_iv(intervals_y_reg);
    r  = (row_pos > ny) ? ny : row_pos;
    c  = (col_pos > nx) ? nx : col_pos;
    above = row_above_mem[c];
    if (r > 0 && c > 0) batch.push_back(make_point(2*r-1, 2*c-1, mean_of(diag_val, v)));
    if (r > 0)          batch.push_back(make_point(2*r-1, 2*c, mean_of(above, v)));
    if (c > 0)          batch.push_back(make_point(2*r, 2*c-1, mean_of(left_val, v)));
    batch.push_back(make_point(2*r, 2*c, v));
    batch[batch.size()-1].last_in = 1'b1;
    diag_val = above;
    row_above_mem[c] = v;
    left_val = v;
    if (c >= nx) begin
      col_pos  = 0;
      left_val = '0;
      diag_val = '0;
      if (r >= ny) begin
        batch[batch.size()-1].last_grid = 1'b1;
        row_pos = 0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
    foreach (batch[i]) expected_fine_points.push_back(batch[i]);
  endtask

  // source side: the head of coarse_queue stays put until its transfer
  always @(posedge clk_i) begin
    bit offer;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        prolongate_sample(coarse_queue.pop_front());
        samples_sent++;
        offer = 1'b0;
      end
      if (!offer && coarse_queue.size() > 0)
        offer = (samples_sent >= 60 && samples_sent < 100) || $urandom_range(99) >= 35;
      s_axis_tvalid <= offer;
      if (offer) s_axis_tdata <= coarse_queue[0];
    end
  end

  // one long back-pressure stretch so the block fills and stalls its input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && points_seen >= 80) begin
        hold_done <= 1'b1;
        hold_left <= 300;
      end
    end
  end

  // sink side: check each transfer, then pick tready for the next edge
  always @(posedge clk_i) begin
    fine_point_t exp_pt;
    bit ready;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        points_seen++;
        if (expected_fine_points.size() == 0) begin
          $error("unexpected fine point row %0d col %0d", m_axis_tdata[11:0],
                 m_axis_tdata[23:12]);
          mismatches++;
        end else begin
          exp_pt = expected_fine_points.pop_front();
          if (m_axis_tdata[11:0] !== exp_pt.row) begin
            $error("fine_row: expected %0d, got %0d", exp_pt.row, m_axis_tdata[11:0]);
            mismatches++;
          end
          if (m_axis_tdata[23:12] !== exp_pt.col) begin
            $error("fine_col: expected %0d, got %0d", exp_pt.col, m_axis_tdata[23:12]);
            mismatches++;
          end
          if (m_axis_tdata[55:24] !== exp_pt.value) begin
            $error("fine_value: expected %h, got %h", exp_pt.value, m_axis_tdata[55:24]);
            mismatches++;
          end
          if (m_axis_tuser[0] !== exp_pt.last_in) begin
            $error("last_of_input: expected %b, got %b", exp_pt.last_in, m_axis_tuser[0]);
            mismatches++;
          end
          if (m_axis_tlast !== exp_pt.last_grid) begin
            $error("last_of_grid: expected %b, got %b", exp_pt.last_grid, m_axis_tlast);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        ready = 1'b0;
      end else begin
        ready = (points_seen >= 150 && points_seen < 250) || $urandom_range(99) >= 35;
      end
      m_axis_tready <= ready;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("seven_point_grid_prolongation: mismatch");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (coarse_queue.size() != 0 || s_axis_tvalid || expected_fine_points.size() != 0);
    // extra margin after the last checked point
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_interval(input spgp_pkg::cfg_reg_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == spgp_pkg::REG_INTERVALS_X) intervals_x_reg = val;
    else intervals_y_reg = val;
    // any write restarts the grid
    left_val = '0;
    diag_val = '0;
    col_pos  = 0;
    row_pos  = 0;
  endtask

  initial begin
    foreach (row_above_mem[i]) row_above_mem[i] = '0;
    left_val = '0;
    diag_val = '0;
    col_pos  = 0;
    row_pos  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    foreach (directed_samples[i]) coarse_queue.push_back(directed_samples[i]);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_interval(spgp_pkg::REG_INTERVALS_X, phase_x[p]);
      write_interval(spgp_pkg::REG_INTERVALS_Y, phase_y[p]);
      @(negedge clk_i);
      for (int n = 0; n < phase_items[p]; n++) coarse_queue.push_back(random_sample());
      wait_idle();
    end

    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && expected_fine_points.size() == 0) begin
      $display("seven_point_grid_prolongation: match");
    end else begin
      $display("seven_point_grid_prolongation: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/spgp_pkg.sv
hw/rtl/spgp_ram.sv
hw/rtl/spgp_fifo.sv
hw/rtl/spgp_front.sv
hw/rtl/spgp_back.sv
hw/rtl/seven_point_grid_prolongation.sv
test/tb_seven_point_grid_prolongation.sv
